[sv/assert_macros.svh]
// Assertion macros used by the top level of the double-ended queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is low.
`define DEQU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define DEQU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/dequ_pkg.sv]
// Package with the types and codes of the double-ended queue.
`timescale 1ns / 1ps

package dequ_pkg;

   // Fixed widths of the item fields.
   localparam int CMD_WIDTH       = 3;
   localparam int WORD_WIDTH      = 32;
   localparam int COUNT_OUT_WIDTH = 7;

   // Command codes of an input item.
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_BACK   = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_REVERSE    = 3'd4,
      CMD_STATUS     = 3'd5
   } dequ_cmd_type;

   // Input item.
   typedef struct packed {
      logic [CMD_WIDTH-1:0]  command;
      logic [WORD_WIDTH-1:0] data_in;
   } dequ_req_type;

   // Result item.
   typedef struct packed {
      logic [WORD_WIDTH-1:0]      data_out;
      logic                       data_valid;
      logic                       underflow;
      logic                       overflow;
      logic [COUNT_OUT_WIDTH-1:0] entry_count;
      logic                       is_empty;
   } dequ_rsp_type;

   // Controller states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } dequ_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
   } dequ_ctrl_type;

endpackage

[sv/dequ_ctrl.sv]
// Controller state machine of the double-ended queue.
`timescale 1ns / 1ps

module dequ_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   output dequ_pkg::dequ_ctrl_type ctrl
);
   import dequ_pkg::*;

   dequ_state_type state_ff, state_in;

   // Next state: accept, execute, then present the result for one cycle.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = start ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs decoded from the state.
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign ctrl.load = (state_ff == ST_IDLE) && start;
   assign ctrl.exec = (state_ff == ST_EXEC);

endmodule

[sv/dequ_dpath.sv]
// Datapath of the double-ended queue: pointers, count, orientation and element memory.
`timescale 1ns / 1ps

module dequ_dpath #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dequ_pkg::dequ_ctrl_type ctrl,
   input  dequ_pkg::dequ_req_type  req_item,
   output dequ_pkg::dequ_rsp_type  rsp_item
);
   import dequ_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = PW + 1;

   dequ_req_type            req_ff, req_in;
   logic [PW-1:0]           head_ff, head_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rev_ff, rev_in;
   logic                    valid_ff, valid_in;
   logic                    under_ff, under_in;
   logic                    over_ff, over_in;
   logic [DATA_WIDTH-1:0]   rd_data_ff;
   logic [DATA_WIDTH-1:0]   mem [DEPTH];

   logic                    wr_en;
   logic                    rd_en;
   logic [PW-1:0]           mem_addr;
   logic [DATA_WIDTH-1:0]   push_word;
   logic [CMD_WIDTH-1:0]    phys_cmd;
   logic                    full;
   logic                    empty;
   logic [SW-1:0]           tail_sum;
   logic [SW-1:0]           last_sum;
   logic [SW-1:0]           tail_wrap;
   logic [SW-1:0]           last_wrap;
   logic [PW-1:0]           head_prev;
   logic [PW-1:0]           head_next;
   logic [63:0]             word_wide;

   // Slot arithmetic modulo the depth; each sum stays below twice the depth.
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign tail_sum  = SW'(head_ff) + SW'(count_ff);
   assign last_sum  = tail_sum - SW'(1);
   assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
   assign last_wrap = (last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum;
   assign head_prev = (head_ff == '0) ? PW'(DEPTH - 1) : head_ff - PW'(1);
   assign head_next = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
   assign push_word = DATA_WIDTH'(req_ff.data_in);

   // When reversed, the logical ends of the push and pop commands swap.
   always_comb begin
      phys_cmd = req_ff.command;
      if (rev_ff && !phys_cmd[2]) begin
         phys_cmd[0] = ~phys_cmd[0];
      end
   end

   // Command execution and next state of the queue registers.
   always_comb begin
      req_in   = ctrl.load ? req_item : req_ff;
      head_in  = head_ff;
      count_in = count_ff;
      rev_in   = rev_ff;
      valid_in = valid_ff;
      under_in = under_ff;
      over_in  = over_ff;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      mem_addr = head_ff;
      if (ctrl.exec) begin
         valid_in = 1'b0;
         under_in = 1'b0;
         over_in  = 1'b0;
         unique case (phys_cmd)
            CMD_PUSH_BACK: begin
               if (full) begin
                  over_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  mem_addr = PW'(tail_wrap);
                  count_in = count_ff + CW'(1);
               end
            end
            CMD_PUSH_FRONT: begin
               if (full) begin
                  over_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  mem_addr = head_prev;
                  head_in  = head_prev;
                  count_in = count_ff + CW'(1);
               end
            end
            CMD_POP_BACK: begin
               if (empty) begin
                  under_in = 1'b1;
               end else begin
                  rd_en    = 1'b1;
                  valid_in = 1'b1;
                  mem_addr = PW'(last_wrap);
                  count_in = count_ff - CW'(1);
               end
            end
            CMD_POP_FRONT: begin
               if (empty) begin
                  under_in = 1'b1;
               end else begin
                  rd_en    = 1'b1;
                  valid_in = 1'b1;
                  mem_addr = head_ff;
                  head_in  = head_next;
                  count_in = count_ff - CW'(1);
               end
            end
            CMD_REVERSE: begin
               rev_in = ~rev_ff;
            end
            default: begin
               // Status and unused codes leave the queue unchanged.
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

   // Item and result flag registers.
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      valid_ff <= valid_in;
      under_ff <= under_in;
      over_ff  <= over_in;
   end

   // Element memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[mem_addr] <= push_word;
      end
      if (rd_en) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   // Result item, valid in the cycle after execution.
   assign word_wide            = 64'(rd_data_ff);
   assign rsp_item.data_out    = valid_ff ? word_wide[WORD_WIDTH-1:0] : '0;
   assign rsp_item.data_valid  = valid_ff;
   assign rsp_item.underflow   = under_ff;
   assign rsp_item.overflow    = over_ff;
   assign rsp_item.entry_count = COUNT_OUT_WIDTH'(count_ff);
   assign rsp_item.is_empty    = empty;

endmodule

[sv/double_ended_queue_core.sv]
// Top level of the double-ended queue: controller, datapath and checks.
`timescale 1ns / 1ps

// The queue works on one item at a time. An item is accepted at an edge
// where start is high and busy is low; the next cycle executes it (pointer and
// count update, one access to the element memory), and the cycle after that
// shows the result on rsp_item with rsp_valid high for exactly that one cycle.
// The receiver cannot stall, so it must take the result in that cycle. The
// pacing is set by the controller: busy stays high through the execute
// cycle and the result cycle, and the next item is taken at the edge that ends
// the idle cycle after the result. The result cycle follows execution because
// the element memory has a registered read port. The memory is not cleared at
// reset; only entries that have been pushed are ever popped.

`include "assert_macros.svh"

module double_ended_queue_core #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  dequ_pkg::dequ_req_type req_item,
   output logic                  rsp_valid,
   output dequ_pkg::dequ_rsp_type rsp_item
);
   import dequ_pkg::*;

   dequ_ctrl_type ctrl;

   // Sequencer.
   dequ_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl)
   );

   // Queue state and element memory.
   dequ_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

   // Checks on the sequencing and the result flags.
   `DEQU_ASSERT(a_accept_busy, clock, reset,
                (start && !busy) |=> busy,
                "accepted item did not raise busy")
   `DEQU_ASSERT(a_rsp_one_cycle, clock, reset,
                rsp_valid |=> !rsp_valid,
                "result strobe longer than one cycle")
   `DEQU_ASSERT(a_rsp_while_busy, clock, reset,
                rsp_valid |-> (busy && !ctrl.load && !ctrl.exec),
                "result strobe outside the result cycle")
   `DEQU_ASSERT(a_underflow_no_data, clock, reset,
                (rsp_valid && rsp_item.underflow) |->
                   (!rsp_item.data_valid && (rsp_item.data_out == '0)),
                "underflow result carries data")

endmodule
